// File: sv/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, pipeline records, per-step functions and the output saturation
// function for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 18;
    localparam int SUM_W     = DW + 3;
    localparam int DIFF_W    = DW + 1;
    localparam int MAG_W     = DIFF_W;
    localparam int ARG_W     = DW + 1;
    localparam int RAD_W     = ((ARG_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SR_W      = ROOT_W + 2;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int REM_W     = DEN_W;
    localparam int QUO_W     = NUM_W - FRAC_BITS / 2 - 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int LANES     = 3;
    localparam int ONE_VAL   = 1 << FRAC_BITS;
    localparam int OUT_MAX   = (1 << (DW - 1)) - 1;

    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } comp_t;

    typedef struct packed {
        comp_t sel;
        logic  bad;
    } meta_t;

    typedef struct packed {
        meta_t                         meta;
        logic [RAD_W-1:0]              rad;
        logic [SR_W-1:0]               rem;
        logic [ROOT_W-1:0]             root;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][MAG_W-1:0]   mag;
    } sq_t;

    typedef struct packed {
        meta_t                         meta;
        logic [ROOT_W-1:0]             root;
        logic [DEN_W-1:0]              den;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][QUO_W-1:0]   num;
        logic [LANES-1:0][REM_W-1:0]   rem;
        logic [LANES-1:0][QUO_W-1:0]   quo;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t a);
        sq_t             b;
        logic [SR_W+1:0] t;
        logic [SR_W+1:0] tr;
        b   = a;
        t   = {a.rem, a.rad[RAD_W-1 -: 2]};
        tr  = {{(SR_W-ROOT_W){1'b0}}, a.root, 2'b01};
        b.rad = a.rad << 2;
        if (t >= tr)
        begin
            b.rem  = SR_W'(t - tr);
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            b.rem  = t[SR_W-1:0];
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    function automatic dv_t div_step(input dv_t a);
        dv_t              b;
        logic [REM_W:0]   r2;
        b = a;
        for (int l = 0; l < LANES; l++)
        begin
            r2 = {a.rem[l], a.num[l][QUO_W-1]};
            b.num[l] = a.num[l] << 1;
            if (r2 >= {1'b0, a.den})
            begin
                b.rem[l] = REM_W'(r2 - {1'b0, a.den});
                b.quo[l] = {a.quo[l][QUO_W-2:0], 1'b1};
            end
            else
            begin
                b.rem[l] = r2[REM_W-1:0];
                b.quo[l] = {a.quo[l][QUO_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    function automatic logic [DW-1:0] sat_out(input logic neg, input logic [QUO_W-1:0] q);
        logic [DW-1:0] r;
        if (!neg)
        begin
            r = (q > QUO_W'(OUT_MAX)) ? DW'(OUT_MAX) : q[DW-1:0];
        end
        else
        begin
            r = (q > QUO_W'(OUT_MAX + 1)) ? {1'b1, {(DW-1){1'b0}}} : (~q[DW-1:0] + 1'b1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Trace-method conversion of a Q1.16 rotation matrix to a unit quaternion
// through a bit-per-stage square root and three bit-per-stage dividers.
// ----------------------------------------------------------------------------
// Pipeline: from accepted matrix to quaternion, 1 select stage, 18 square-root
//   stages, 1 divider setup stage, 26 divider stages and 1 output stage.
// Throughput: one transaction per cycle; the whole pipeline holds on a stall
//   at the output register.
// Reset: rst_n clears all stage valid bits; the data path is not reset.
module rotation_matrix_to_quaternion (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          mat_valid,
    output logic                               mat_stall,
    input  wire logic signed [rmq_pkg::DW-1:0] m00,
    input  wire logic signed [rmq_pkg::DW-1:0] m01,
    input  wire logic signed [rmq_pkg::DW-1:0] m02,
    input  wire logic signed [rmq_pkg::DW-1:0] m10,
    input  wire logic signed [rmq_pkg::DW-1:0] m11,
    input  wire logic signed [rmq_pkg::DW-1:0] m12,
    input  wire logic signed [rmq_pkg::DW-1:0] m20,
    input  wire logic signed [rmq_pkg::DW-1:0] m21,
    input  wire logic signed [rmq_pkg::DW-1:0] m22,
    output logic                               quat_valid,
    input  wire logic                          quat_stall,
    output logic signed [rmq_pkg::DW-1:0]      qw,
    output logic signed [rmq_pkg::DW-1:0]      qx,
    output logic signed [rmq_pkg::DW-1:0]      qy,
    output logic signed [rmq_pkg::DW-1:0]      qz,
    output logic                               bad_matrix
);
    import rmq_pkg::*;

    logic adv;

    logic signed [SUM_W-1:0]  trace;
    logic signed [SUM_W-1:0]  arg;
    logic signed [DIFF_W-1:0] dpos [0:3];
    logic signed [DIFF_W-1:0] dl;
    comp_t                    sel;
    sq_t                      sq_next;

    logic                     sq_vld_reg [0:SQ_STEPS];
    sq_t                      sq_reg     [0:SQ_STEPS];
    logic                     dv_vld_reg [0:DIV_STEPS];
    dv_t                      dv_reg     [0:DIV_STEPS];
    dv_t                      dv_next;
    logic [NUM_W-1:0]         num_full;

    logic                     out_valid_reg;
    logic [DW-1:0]            out_q_reg [0:3];
    logic                     out_bad_reg;
    logic [DW-1:0]            out_q_next [0:3];
    logic [1:0]               lane;
    dv_t                      fin;

    assign adv       = !out_valid_reg || !quat_stall;
    assign mat_stall = !adv;

    always_comb
    begin
        trace = SUM_W'(m00) + SUM_W'(m11) + SUM_W'(m22);
        dpos[0] = '0;
        dpos[1] = '0;
        dpos[2] = '0;
        dpos[3] = '0;
        if (trace > 0)
        begin
            sel     = COMP_W;
            arg     = trace + SUM_W'(ONE_VAL);
            dpos[1] = DIFF_W'(m21) - DIFF_W'(m12);
            dpos[2] = DIFF_W'(m02) - DIFF_W'(m20);
            dpos[3] = DIFF_W'(m10) - DIFF_W'(m01);
        end
        else
        begin
            sel = COMP_X;
            if (m11 > m00)
            begin
                sel = COMP_Y;
            end
            if ((sel == COMP_X && m22 > m00) || (sel == COMP_Y && m22 > m11))
            begin
                sel = COMP_Z;
            end
            case (sel)
                COMP_X:
                begin
                    arg     = SUM_W'(m00) - SUM_W'(m11) - SUM_W'(m22) + SUM_W'(ONE_VAL);
                    dpos[0] = DIFF_W'(m21) - DIFF_W'(m12);
                    dpos[2] = DIFF_W'(m10) + DIFF_W'(m01);
                    dpos[3] = DIFF_W'(m20) + DIFF_W'(m02);
                end
                COMP_Y:
                begin
                    arg     = SUM_W'(m11) - SUM_W'(m22) - SUM_W'(m00) + SUM_W'(ONE_VAL);
                    dpos[0] = DIFF_W'(m02) - DIFF_W'(m20);
                    dpos[3] = DIFF_W'(m21) + DIFF_W'(m12);
                    dpos[1] = DIFF_W'(m01) + DIFF_W'(m10);
                end
                default:
                begin
                    arg     = SUM_W'(m22) - SUM_W'(m00) - SUM_W'(m11) + SUM_W'(ONE_VAL);
                    dpos[0] = DIFF_W'(m10) - DIFF_W'(m01);
                    dpos[1] = DIFF_W'(m02) + DIFF_W'(m20);
                    dpos[2] = DIFF_W'(m12) + DIFF_W'(m21);
                end
            endcase
        end

        sq_next.meta.sel = sel;
        sq_next.meta.bad = (arg <= 0);
        sq_next.rad      = RAD_W'({arg[ARG_W-1:0], {FRAC_BITS{1'b0}}});
        sq_next.rem      = '0;
        sq_next.root     = '0;
        for (int l = 0; l < LANES; l++)
        begin
            dl = (2'(l) >= sel) ? dpos[l+1] : dpos[l];
            sq_next.neg[l] = dl[DIFF_W-1];
            sq_next.mag[l] = dl[DIFF_W-1] ? MAG_W'(-dl) : MAG_W'(dl);
        end
    end

    always_comb
    begin
        dv_next.meta = sq_reg[SQ_STEPS].meta;
        dv_next.root = sq_reg[SQ_STEPS].root;
        dv_next.den  = {sq_reg[SQ_STEPS].root, 1'b0};
        dv_next.neg  = sq_reg[SQ_STEPS].neg;
        num_full     = '0;
        for (int l = 0; l < LANES; l++)
        begin
            num_full = {sq_reg[SQ_STEPS].mag[l], {FRAC_BITS{1'b0}}}
                       + NUM_W'(sq_reg[SQ_STEPS].root);
            dv_next.num[l] = num_full[QUO_W-1:0];
            dv_next.rem[l] = REM_W'(num_full[NUM_W-1:QUO_W]);
            dv_next.quo[l] = '0;
        end
    end

    always_comb
    begin
        fin  = dv_reg[DIV_STEPS];
        lane = '0;
        for (int p = 0; p < 4; p++)
        begin
            lane = (2'(p) > fin.meta.sel) ? 2'(p - 1) : 2'(p);
            if (fin.meta.bad)
            begin
                out_q_next[p] = '0;
            end
            else if (2'(p) == fin.meta.sel)
            begin
                out_q_next[p] = DW'(fin.root >> 1);
            end
            else
            begin
                out_q_next[p] = sat_out(fin.neg[lane], fin.quo[lane]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= SQ_STEPS; s++)
            begin
                sq_vld_reg[s] <= 1'b0;
            end
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= mat_valid;
            for (int s = 1; s <= SQ_STEPS; s++)
            begin
                sq_vld_reg[s] <= sq_vld_reg[s-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
            out_valid_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_next;
            for (int s = 1; s <= SQ_STEPS; s++)
            begin
                sq_reg[s] <= sqrt_step(sq_reg[s-1]);
            end
            dv_reg[0] <= dv_next;
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dv_reg[s] <= div_step(dv_reg[s-1]);
            end
            for (int p = 0; p < 4; p++)
            begin
                out_q_reg[p] <= out_q_next[p];
            end
            out_bad_reg <= fin.meta.bad;
        end
    end

    assign quat_valid = out_valid_reg;
    assign qw         = out_q_reg[0];
    assign qx         = out_q_reg[1];
    assign qy         = out_q_reg[2];
    assign qz         = out_q_reg[3];
    assign bad_matrix = out_bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && bad_matrix |-> qw == '0 && qx == '0 && qy == '0 && qz == '0)
        else $error("bad matrix result not zero");

    a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_STEPS] && !dv_reg[DIV_STEPS].meta.bad
            |-> dv_reg[DIV_STEPS].root >= ROOT_W'(1 << (FRAC_BITS / 2)))
        else $error("square root below unit argument bound");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DIV_STEPS] && !dv_reg[DIV_STEPS].meta.bad
            |-> dv_reg[DIV_STEPS].rem[0] < dv_reg[DIV_STEPS].den
             && dv_reg[DIV_STEPS].rem[1] < dv_reg[DIV_STEPS].den
             && dv_reg[DIV_STEPS].rem[2] < dv_reg[DIV_STEPS].den)
        else $error("divider remainder out of range");

endmodule
`default_nettype wire
